[rtl/assert_macros.svh]
// Assertion macros shared by the list engine RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: %m");

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen: %m");

`endif

[rtl/alle_pkg.sv]
// Package of the array linked list engine: sizes, codes and command types.
// Depends on nothing; used by every other file of the block except assert_macros.svh.
package alle_pkg;

    // Node store size and derived widths.
    localparam int CAPACITY = 32;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_APPEND   = 2'd0,
        OP_READ_FWD = 2'd1,
        OP_READ_ROT = 2'd2,
        OP_READ_REV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_SINGLE = 2'd3
    } status_t;

    // What the back end has to do for one transaction.
    typedef enum logic [2:0] {
        CMD_APPEND,
        CMD_STATUS,
        CMD_FWD,
        CMD_ROT,
        CMD_REV
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        status_t                   status;
        logic [CNT_W-1:0]          len;
        logic [IDX_W-1:0]          addr;
        logic signed [DATA_W-1:0]  value;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_STATUS,
        B_EMIT
    } back_state_t;

endpackage

[rtl/alle_if.sv]
// Request and response channel interfaces of the list engine.
// Depends on alle_pkg for the operation and status codes.
interface alle_req_if;
    logic                              valid;
    logic                              ready;
    alle_pkg::op_t                     op;
    logic signed [alle_pkg::DATA_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface alle_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [alle_pkg::DATA_W-1:0] item;
    alle_pkg::status_t                 status;
    logic                              last;

    modport source (output valid, output item, output status, output last, input ready);
    modport sink   (input valid, input item, input status, input last, output ready);
endinterface

[rtl/alle_front.sv]
// Front end: accepts request transactions and classifies them into commands.
// Depends on alle_pkg, alle_if and assert_macros.svh.
`include "assert_macros.svh"

module alle_front (
    input  logic            clk,
    input  logic            rst_n,
    alle_req_if.sink        req,
    output logic            push_valid,
    input  logic            push_ready,
    output alle_pkg::cmd_t  push_data
);

    // Number of nodes on the list. The free chain hands out nodes in index
    // order and nodes are never returned, so list element k is node k.
    logic [alle_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       is_full;
    logic                       is_empty;

    assign req.ready  = push_ready;
    assign push_valid = req.valid;
    assign is_full    = (count_reg == alle_pkg::CNT_W'(alle_pkg::CAPACITY));
    assign is_empty   = (count_reg == '0);

    // Classification against the list length seen by this command.
    always_comb
    begin
        push_data.kind   = alle_pkg::CMD_STATUS;
        push_data.status = alle_pkg::ST_OK;
        push_data.len    = count_reg;
        push_data.addr   = count_reg[alle_pkg::IDX_W-1:0];
        push_data.value  = req.value;
        case (req.op)
            alle_pkg::OP_APPEND:
            begin
                if (is_full)
                    push_data.status = alle_pkg::ST_FULL;
                else
                    push_data.kind = alle_pkg::CMD_APPEND;
            end
            alle_pkg::OP_READ_FWD:
            begin
                if (is_empty)
                    push_data.status = alle_pkg::ST_EMPTY;
                else
                    push_data.kind = alle_pkg::CMD_FWD;
            end
            alle_pkg::OP_READ_ROT:
            begin
                if (is_empty)
                    push_data.status = alle_pkg::ST_EMPTY;
                else if (count_reg == alle_pkg::CNT_W'(1))
                    push_data.status = alle_pkg::ST_SINGLE;
                else
                    push_data.kind = alle_pkg::CMD_ROT;
            end
            alle_pkg::OP_READ_REV:
            begin
                if (is_empty)
                    push_data.status = alle_pkg::ST_EMPTY;
                else
                    push_data.kind = alle_pkg::CMD_REV;
            end
            default:
            begin
                push_data.status = alle_pkg::ST_EMPTY;
            end
        endcase
    end

    // A successful append takes the next free node.
    always_comb
    begin
        count_next = count_reg;
        if (req.valid && req.ready && push_data.kind == alle_pkg::CMD_APPEND)
            count_next = count_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    `ASSERT_AT(a_count_step, clk, rst_n, (req.valid && req.ready && push_data.kind == alle_pkg::CMD_APPEND) |=> (count_reg == $past(count_reg) + 1'b1))
    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > alle_pkg::CNT_W'(alle_pkg::CAPACITY))

endmodule

[rtl/alle_cmd_queue.sv]
// Short command queue that decouples the front end from the back end.
// Depends on alle_pkg and assert_macros.svh.
`include "assert_macros.svh"

module alle_cmd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  alle_pkg::cmd_t  push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output alle_pkg::cmd_t  pop_data
);

    alle_pkg::cmd_t              slots_reg [alle_pkg::QUEUE_DEPTH];
    logic [alle_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [alle_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [alle_pkg::QCNT_W-1:0] fill_reg, fill_next;
    logic                        do_push;
    logic                        do_pop;

    assign push_ready = (fill_reg != alle_pkg::QCNT_W'(alle_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_data   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping with explicit wrap.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == alle_pkg::QPTR_W'(alle_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == alle_pkg::QPTR_W'(alle_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Slot payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_data;
    end

    `ASSERT_AT(a_fill_tracks_push, clk, rst_n, (do_push && !do_pop) |=> (fill_reg == $past(fill_reg) + 1'b1))

endmodule

[rtl/alle_back.sv]
// Back end: holds the node store and carries out commands, one result per cycle of a read while rsp.ready holds.
// Depends on alle_pkg, alle_if and assert_macros.svh.
`include "assert_macros.svh"

module alle_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  alle_pkg::cmd_t  cmd,
    alle_rsp_if.source      rsp
);

    // Node value store with registered read.
    logic signed [alle_pkg::DATA_W-1:0] store_mem [alle_pkg::CAPACITY];
    logic signed [alle_pkg::DATA_W-1:0] rd_data_reg;
    logic [alle_pkg::IDX_W-1:0]         rd_addr;
    logic                               store_we;

    alle_pkg::back_state_t       state_reg, state_next;
    alle_pkg::cmd_kind_t         kind_reg, kind_next;
    alle_pkg::status_t           status_reg, status_next;
    logic [alle_pkg::CNT_W-1:0]  len_reg, len_next;
    logic [alle_pkg::IDX_W-1:0]  k_reg, k_next;
    logic                        take;
    logic                        sent;
    logic                        at_end;

    // Store entry that holds result number j of a read of len elements.
    function automatic logic [alle_pkg::IDX_W-1:0] elem_addr(
        input alle_pkg::cmd_kind_t        kind,
        input logic [alle_pkg::CNT_W-1:0] len,
        input logic [alle_pkg::IDX_W-1:0] j
    );
        logic [alle_pkg::CNT_W-1:0] rev;
        logic [alle_pkg::IDX_W-1:0] res;
        rev = len - 1'b1 - alle_pkg::CNT_W'(j);
        case (kind)
            alle_pkg::CMD_REV:
                res = rev[alle_pkg::IDX_W-1:0];
            alle_pkg::CMD_ROT:
                res = (alle_pkg::CNT_W'(j) == len - 1'b1) ? '0 : j + 1'b1;
            default:
                res = j;
        endcase
        return res;
    endfunction

    assign cmd_ready  = (state_reg == alle_pkg::B_IDLE);
    assign take       = cmd_valid && cmd_ready;
    assign at_end     = (alle_pkg::CNT_W'(k_reg) == len_reg - 1'b1);
    assign sent       = rsp.valid && rsp.ready;

    // Response fields come straight from registers.
    assign rsp.valid  = (state_reg != alle_pkg::B_IDLE);
    assign rsp.item   = (state_reg == alle_pkg::B_EMIT) ? rd_data_reg : '0;
    assign rsp.status = status_reg;
    assign rsp.last   = (state_reg == alle_pkg::B_STATUS) || at_end;

    // Sequencer: next state, store write and read address.
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        len_next    = len_reg;
        k_next      = k_reg;
        store_we    = 1'b0;
        rd_addr     = elem_addr(kind_reg, len_reg, k_reg);
        case (state_reg)
            alle_pkg::B_IDLE:
            begin
                if (take)
                begin
                    kind_next   = cmd.kind;
                    len_next    = cmd.len;
                    k_next      = '0;
                    status_next = alle_pkg::ST_OK;
                    rd_addr     = elem_addr(cmd.kind, cmd.len, '0);
                    case (cmd.kind)
                        alle_pkg::CMD_APPEND:
                        begin
                            store_we   = 1'b1;
                            state_next = alle_pkg::B_STATUS;
                        end
                        alle_pkg::CMD_STATUS:
                        begin
                            status_next = cmd.status;
                            state_next  = alle_pkg::B_STATUS;
                        end
                        alle_pkg::CMD_FWD, alle_pkg::CMD_ROT, alle_pkg::CMD_REV:
                        begin
                            state_next = alle_pkg::B_EMIT;
                        end
                        default:
                        begin
                            state_next = alle_pkg::B_IDLE;
                        end
                    endcase
                end
            end
            alle_pkg::B_STATUS:
            begin
                if (sent)
                    state_next = alle_pkg::B_IDLE;
            end
            alle_pkg::B_EMIT:
            begin
                if (sent)
                begin
                    if (at_end)
                        state_next = alle_pkg::B_IDLE;
                    else
                    begin
                        k_next  = k_reg + 1'b1;
                        rd_addr = elem_addr(kind_reg, len_reg, k_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = alle_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= alle_pkg::B_IDLE;
            kind_reg   <= alle_pkg::CMD_STATUS;
            status_reg <= alle_pkg::ST_OK;
            len_reg    <= '0;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            status_reg <= status_next;
            len_reg    <= len_next;
            k_reg      <= k_next;
        end
    end

    // Store write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[cmd.addr] <= cmd.value;
        rd_data_reg <= store_mem[rd_addr];
    end

    `ASSERT_AT(a_last_returns_idle, clk, rst_n, (rsp.valid && rsp.ready && rsp.last) |=> (state_reg == alle_pkg::B_IDLE))
    `ASSERT_AT(a_step_in_range, clk, rst_n, (state_reg == alle_pkg::B_EMIT) |-> (alle_pkg::CNT_W'(k_reg) < len_reg))

endmodule

[rtl/array_linked_list_engine.sv]
// Array linked list engine: append and three read orders over a node store.
// Results pass the queue slot, then the back end's registered state and store
// read. The back end takes a command, then does one store read per result of
// a read; it takes no new command until its last result goes. Reset empties
// the list and frees every node at once; stored values are not cleared, and no
// clearing pass runs. Depends on alle_pkg, alle_if and front, queue, back.
module array_linked_list_engine (
    input  logic        clk,
    input  logic        rst_n,
    alle_req_if.sink    req,
    alle_rsp_if.source  rsp
);

    logic           push_valid;
    logic           push_ready;
    alle_pkg::cmd_t push_data;
    logic           pop_valid;
    logic           pop_ready;
    alle_pkg::cmd_t pop_data;

    // Classification of request transactions.
    alle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Command queue between the two halves.
    alle_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Execution against the node store.
    alle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_data),
        .rsp       (rsp)
    );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the array linked list engine: appends and the three read orders.
// Depends on alle_pkg, alle_req_if, alle_rsp_if and array_linked_list_engine of the RTL.
module tb_top;

    localparam int RANDOM_ITEMS   = 314;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PERCENT   = 21;
    localparam int CALM_START     = 800;
    localparam int CALM_END       = 2800;
    localparam int HOLD_TRIGGER   = 150;
    localparam int HOLD_CYCLES    = 400;

    typedef struct {
        alle_pkg::op_t                       op;
        logic signed [alle_pkg::DATA_W-1:0]  value;
    } list_cmd_t;

    typedef struct {
        logic signed [alle_pkg::DATA_W-1:0]  item;
        alle_pkg::status_t                   status;
        logic                                is_last;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    alle_req_if req_ch ();
    alle_rsp_if rsp_ch ();

    array_linked_list_engine i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Commands waiting to be offered and results the list should produce.
    list_cmd_t pending_cmd_q[$];
    list_rsp_t expected_rsp_q[$];

    // Shadow copy of the node store, the list head and the free chain.
    logic signed [alle_pkg::DATA_W-1:0] list_vals    [alle_pkg::CAPACITY];
    logic [alle_pkg::IDX_W-1:0]         list_next    [alle_pkg::CAPACITY];
    logic                               list_next_ok [alle_pkg::CAPACITY];
    logic [alle_pkg::IDX_W-1:0]         head_idx;
    logic                               head_ok;
    logic [alle_pkg::IDX_W-1:0]         free_idx;
    logic                               free_ok;

    int  total_cmds;
    int  accepted_cnt;
    int  err_cnt;
    int  cycle_cnt;
    int  quiet_cycles;
    bit  req_taken;
    bit  calm;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void push_expect(input logic signed [alle_pkg::DATA_W-1:0] item,
                                         input alle_pkg::status_t status,
                                         input logic is_last);
        list_rsp_t r;
        r.item    = item;
        r.status  = status;
        r.is_last = is_last;
        expected_rsp_q.push_back(r);
    endfunction

    // Applies one accepted transaction to the shadow list and queues its results.
    task automatic list_model_apply(input alle_pkg::op_t op,
                                    input logic signed [alle_pkg::DATA_W-1:0] value);
        logic signed [alle_pkg::DATA_W-1:0] walk_vals [alle_pkg::CAPACITY];
        logic [alle_pkg::IDX_W-1:0]         cur;
        logic [alle_pkg::IDX_W-1:0]         node;
        logic                               cur_ok;
        int                                 cnt;
        int                                 steps;
        int                                 k;
        if (op == alle_pkg::OP_APPEND)
        begin
            if (!free_ok)
            begin
                push_expect('0, alle_pkg::ST_FULL, 1'b1);
                return;
            end
            node = free_idx;
            free_ok = list_next_ok[node];
            free_idx = list_next[node];
            list_vals[node] = value;
            list_next[node] = '0;
            list_next_ok[node] = 1'b0;
            if (!head_ok)
            begin
                head_idx = node;
                head_ok = 1'b1;
            end
            else
            begin
                // Walk to the tail and link the new node behind it.
                cur = head_idx;
                steps = 0;
                while (list_next_ok[cur] && steps < alle_pkg::CAPACITY)
                begin
                    cur = list_next[cur];
                    steps++;
                end
                list_next[cur] = node;
                list_next_ok[cur] = 1'b1;
            end
            push_expect('0, alle_pkg::ST_OK, 1'b1);
            return;
        end

        // Gather the elements in list order.
        cnt = 0;
        cur = head_idx;
        cur_ok = head_ok;
        while (cur_ok && cnt < alle_pkg::CAPACITY)
        begin
            walk_vals[cnt] = list_vals[cur];
            cnt++;
            cur_ok = list_next_ok[cur];
            cur = list_next[cur];
        end
        if (cnt == 0)
        begin
            push_expect('0, alle_pkg::ST_EMPTY, 1'b1);
            return;
        end

        case (op)
            alle_pkg::OP_READ_FWD:
            begin
                for (k = 0; k < cnt; k++)
                    push_expect(walk_vals[k], alle_pkg::ST_OK, k == cnt - 1);
            end
            alle_pkg::OP_READ_ROT:
            begin
                if (cnt == 1)
                    push_expect('0, alle_pkg::ST_SINGLE, 1'b1);
                else
                begin
                    for (k = 1; k < cnt; k++)
                        push_expect(walk_vals[k], alle_pkg::ST_OK, 1'b0);
                    push_expect(walk_vals[0], alle_pkg::ST_OK, 1'b1);
                end
            end
            default:
            begin
                for (k = 0; k < cnt; k++)
                    push_expect(walk_vals[cnt - 1 - k], alle_pkg::ST_OK, k == cnt - 1);
            end
        endcase
    endtask

    function automatic void add_cmd(input alle_pkg::op_t op,
                                    input logic signed [alle_pkg::DATA_W-1:0] value);
        list_cmd_t c;
        c.op    = op;
        c.value = value;
        pending_cmd_q.push_back(c);
    endfunction

    // Monitor: checks results, predicts on accepted requests, runs the watchdog.
    always @(posedge clk or negedge rst_n)
    begin
        list_rsp_t exp_rsp;
        if (!rst_n)
        begin
            req_taken = 1'b0;
            quiet_cycles = 0;
            cycle_cnt = 0;
        end
        else
        begin
            cycle_cnt++;
            calm = (cycle_cnt >= CALM_START) && (cycle_cnt < CALM_END);
            req_taken = req_ch.valid && req_ch.ready;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected result item=%0d status=%0d last=%0b",
                             $time, rsp_ch.item, rsp_ch.status, rsp_ch.last);
                end
                else
                begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (rsp_ch.item !== exp_rsp.item)
                    begin
                        err_cnt++;
                        $display("%0t: item mismatch, expected %0d, actual %0d",
                                 $time, exp_rsp.item, rsp_ch.item);
                    end
                    if (rsp_ch.status !== exp_rsp.status)
                    begin
                        err_cnt++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, exp_rsp.status, rsp_ch.status);
                    end
                    if (rsp_ch.last !== exp_rsp.is_last)
                    begin
                        err_cnt++;
                        $display("%0t: last mismatch, expected %0b, actual %0b",
                                 $time, exp_rsp.is_last, rsp_ch.last);
                    end
                end
            end
            if (req_taken)
            begin
                list_model_apply(req_ch.op, req_ch.value);
                accepted_cnt++;
            end
            if (req_taken || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, expected_rsp_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Request driver: offers the next pending command, idling at random.
    always @(negedge clk)
    begin
        list_cmd_t nxt;
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            if (pending_cmd_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT))
            begin
                nxt = pending_cmd_q.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.op    <= nxt.op;
                req_ch.value <= nxt.value;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus one long hold-off to back up the block.
    always @(negedge clk)
    begin
        int  hold_left;
        bit  hold_done;
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!hold_done && accepted_cnt >= HOLD_TRIGGER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        alle_pkg::op_t rand_op;
        int            i;
        req_ch.valid = 1'b0;
        req_ch.op    = alle_pkg::OP_APPEND;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;
        rst_n        = 1'b0;
        err_cnt      = 0;
        accepted_cnt = 0;
        calm         = 1'b0;

        // Shadow list after reset: empty, every node chained on the free list.
        for (i = 0; i < alle_pkg::CAPACITY; i++)
        begin
            list_vals[i]    = '0;
            list_next[i]    = alle_pkg::IDX_W'(i + 1);
            list_next_ok[i] = (i < alle_pkg::CAPACITY - 1);
        end
        head_idx = '0;
        head_ok  = 1'b0;
        free_idx = '0;
        free_ok  = 1'b1;

        // Directed part: reads of an empty list, the single element rotate,
        // extreme values and each read order on a short list.
        add_cmd(alle_pkg::OP_READ_FWD, 32'sd0);
        add_cmd(alle_pkg::OP_READ_ROT, 32'sd0);
        add_cmd(alle_pkg::OP_READ_REV, 32'sd0);
        add_cmd(alle_pkg::OP_APPEND, 32'sh7FFF_FFFF);
        add_cmd(alle_pkg::OP_READ_ROT, 32'sd0);
        add_cmd(alle_pkg::OP_READ_FWD, 32'sd0);
        add_cmd(alle_pkg::OP_READ_REV, 32'sd0);
        add_cmd(alle_pkg::OP_APPEND, 32'sh8000_0000);
        add_cmd(alle_pkg::OP_READ_ROT, 32'sd0);
        add_cmd(alle_pkg::OP_APPEND, -32'sd1);
        add_cmd(alle_pkg::OP_APPEND, 32'sd0);
        add_cmd(alle_pkg::OP_APPEND, 32'sh5555_5555);
        add_cmd(alle_pkg::OP_APPEND, 32'shAAAA_AAAA);
        add_cmd(alle_pkg::OP_READ_FWD, 32'sd0);
        add_cmd(alle_pkg::OP_READ_ROT, 32'sd0);
        add_cmd(alle_pkg::OP_READ_REV, 32'sd0);

        // Random part: the list grows until the store is full, after which
        // appends report full and every read returns the whole store.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if ($urandom_range(99) < 40)
                add_cmd(alle_pkg::OP_APPEND, $urandom);
            else
            begin
                rand_op = alle_pkg::op_t'($urandom_range(3, 1));
                add_cmd(rand_op, $urandom);
            end
        end
        total_cmds = pending_cmd_q.size();

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        while (accepted_cnt < total_cmds || expected_rsp_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (err_cnt == 0 && expected_rsp_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
